// ===== design/pcol_pkg.sv =====
// Package for the particle-plane collision pipeline.
// Holds field widths, register indexes, reset values and the saturation helper.
// No dependencies.
`default_nettype none

package pcol_pkg;

	localparam int COORD_W = 32;
	localparam int NORM_W  = 18;
	localparam int IDX_W   = 3;
	localparam int LANES   = 3;
	localparam int WIDE_W  = 41;

	typedef enum logic [IDX_W-1:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_POINT_X  = 3'd3,
		REG_POINT_Y  = 3'd4,
		REG_POINT_Z  = 3'd5,
		REG_MARGIN   = 3'd6
	} pcol_reg_t;

	localparam logic signed [NORM_W-1:0]  NORMAL_X_RST = 18'sd0;
	localparam logic signed [NORM_W-1:0]  NORMAL_Y_RST = 18'sd65536;
	localparam logic signed [NORM_W-1:0]  NORMAL_Z_RST = 18'sd0;
	localparam logic signed [COORD_W-1:0] POINT_RST    = 32'sd0;
	localparam logic signed [COORD_W-1:0] MARGIN_RST   = 32'sd0;

	localparam logic signed [WIDE_W-1:0] SAT_MAX = 41'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_MIN = -41'sd2147483648;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[COORD_W-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[COORD_W-1:0];
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/pcol_if.sv =====
// Valid/ready channel interfaces for particle items and corrected results.
// Depends on pcol_pkg for field widths.
`default_nettype none

interface pcol_in_if import pcol_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic signed [COORD_W-1:0] prev_x;
	logic signed [COORD_W-1:0] prev_y;
	logic signed [COORD_W-1:0] prev_z;

	modport source (output valid, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z, output ready);
endinterface

interface pcol_out_if import pcol_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] new_pos_x;
	logic signed [COORD_W-1:0] new_pos_y;
	logic signed [COORD_W-1:0] new_pos_z;
	logic signed [COORD_W-1:0] new_prev_x;
	logic signed [COORD_W-1:0] new_prev_y;
	logic signed [COORD_W-1:0] new_prev_z;
	logic                      collided;

	modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
		new_prev_x, new_prev_y, new_prev_z, collided, input ready);
	modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z,
		new_prev_x, new_prev_y, new_prev_z, collided, output ready);
endinterface

`default_nettype wire

// ===== design/plane_particle_collision_top.sv =====
// Particle-plane collision response: ten-stage fixed-point pipeline.
// Depends on pcol_pkg and the channel interfaces in pcol_if.sv.
// Usage:
//   in_item  carries one particle (current and previous position, Q16.16)
//            per transaction; a transaction completes when valid and ready
//            are both high at a rising edge of clk.
//   out_item carries the corrected positions and the collided flag, one
//            result per particle, in arrival order.
//   cfg_we / cfg_idx / cfg_wdata write the plane normal, plane point and
//            margin; write only while no particle is in flight.
// One particle per cycle is accepted in steady state while out_item.ready
// is high. Each stage has its own valid bit and a stage loads whenever it
// is empty or the stage after it moves, so bubbles collapse and input is
// still taken while a finished result waits at the output register. When
// the receiver stalls, results back up stage by stage and in_item.ready
// falls once all ten are full.
// Stage depth is set by the multipliers (up to 38x18) and by the 53-bit
// dot-product sums.
// arst_n clears every valid bit and loads the default plane (normal +Y
// through the origin, zero margin).
`default_nettype none

module plane_particle_collision_top
	import pcol_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_idx,
	input  wire logic [31:0]      cfg_wdata,
	pcol_in_if.sink               in_item,
	pcol_out_if.source            out_item
);

	logic signed [NORM_W-1:0]  nrm_q [LANES];
	logic signed [COORD_W-1:0] pt_q  [LANES];
	logic signed [COORD_W-1:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q[0] <= NORMAL_X_RST;
			nrm_q[1] <= NORMAL_Y_RST;
			nrm_q[2] <= NORMAL_Z_RST;
			pt_q[0]  <= POINT_RST;
			pt_q[1]  <= POINT_RST;
			pt_q[2]  <= POINT_RST;
			margin_q <= MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NORMAL_X: nrm_q[0] <= cfg_wdata[NORM_W-1:0];
				REG_NORMAL_Y: nrm_q[1] <= cfg_wdata[NORM_W-1:0];
				REG_NORMAL_Z: nrm_q[2] <= cfg_wdata[NORM_W-1:0];
				REG_POINT_X:  pt_q[0]  <= cfg_wdata;
				REG_POINT_Y:  pt_q[1]  <= cfg_wdata;
				REG_POINT_Z:  pt_q[2]  <= cfg_wdata;
				REG_MARGIN:   margin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage valid bits and load enables
	localparam int NS = 10;
	logic [NS:1] v_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !v_q[NS] || out_item.ready;
		for (int k = NS - 1; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign in_item.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= in_item.valid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	logic signed [COORD_W-1:0] pos_in  [LANES];
	logic signed [COORD_W-1:0] prev_in [LANES];

	always_comb begin
		pos_in[0]  = in_item.pos_x;
		pos_in[1]  = in_item.pos_y;
		pos_in[2]  = in_item.pos_z;
		prev_in[0] = in_item.prev_x;
		prev_in[1] = in_item.prev_y;
		prev_in[2] = in_item.prev_z;
	end

	// payload pipeline
	logic signed [32:0]        d_s1 [LANES];
	logic signed [COORD_W-1:0] pos_s1 [LANES], pos_s2 [LANES], pos_s3 [LANES], pos_s4 [LANES];
	logic signed [COORD_W-1:0] prev_s1 [LANES], prev_s2 [LANES], prev_s3 [LANES];
	logic signed [COORD_W-1:0] prev_s4 [LANES], prev_s5 [LANES], prev_s6 [LANES];
	logic signed [COORD_W-1:0] prev_s7 [LANES], prev_s8 [LANES], prev_s9 [LANES];
	logic signed [50:0]        m_s2 [LANES];
	logic signed [37:0]        push_s3;
	logic                      hit_s3, hit_s4, hit_s5, hit_s6, hit_s7, hit_s8, hit_s9, hit_s10;
	logic signed [55:0]        q_s4 [LANES];
	logic signed [COORD_W-1:0] npos_s5 [LANES], npos_s6 [LANES], npos_s7 [LANES];
	logic signed [COORD_W-1:0] npos_s8 [LANES], npos_s9 [LANES], npos_s10 [LANES];
	logic signed [32:0]        e_s6 [LANES];
	logic signed [50:0]        r_s7 [LANES];
	logic signed [36:0]        nv_s8;
	logic                      neg_s8, neg_s9;
	logic signed [54:0]        t_s9 [LANES];
	logic signed [COORD_W-1:0] nprev_s10 [LANES];

	logic signed [52:0]     dsum;
	logic signed [36:0]     sdist;
	logic signed [52:0]     vsum;
	logic signed [36:0]     nv;
	logic signed [WIDE_W-1:0] pos_adj [LANES];
	logic signed [WIDE_W-1:0] prev_adj [LANES];

	always_comb begin
		dsum  = 53'(m_s2[0]) + 53'(m_s2[1]) + 53'(m_s2[2]);
		sdist = $signed(dsum[52:16]);
		vsum  = 53'(r_s7[0]) + 53'(r_s7[1]) + 53'(r_s7[2]);
		nv    = $signed(vsum[52:16]);
		for (int i = 0; i < LANES; i++) begin
			pos_adj[i]  = 41'(pos_s4[i]) + 41'($signed(q_s4[i][55:16]));
			prev_adj[i] = 41'(prev_s9[i]) + 41'($signed(t_s9[i][54:16]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < LANES; i++) begin
				d_s1[i]    <= 33'(pos_in[i]) - 33'(pt_q[i]);
				pos_s1[i]  <= pos_in[i];
				prev_s1[i] <= prev_in[i];
			end
		end
		if (en[2]) begin
			for (int i = 0; i < LANES; i++) begin
				m_s2[i]    <= 51'(d_s1[i]) * 51'(nrm_q[i]);
				pos_s2[i]  <= pos_s1[i];
				prev_s2[i] <= prev_s1[i];
			end
		end
		if (en[3]) begin
			hit_s3  <= sdist < 37'(margin_q);
			push_s3 <= 38'(margin_q) - 38'(sdist);
			for (int i = 0; i < LANES; i++) begin
				pos_s3[i]  <= pos_s2[i];
				prev_s3[i] <= prev_s2[i];
			end
		end
		if (en[4]) begin
			hit_s4 <= hit_s3;
			for (int i = 0; i < LANES; i++) begin
				q_s4[i]    <= 56'(push_s3) * 56'(nrm_q[i]);
				pos_s4[i]  <= pos_s3[i];
				prev_s4[i] <= prev_s3[i];
			end
		end
		if (en[5]) begin
			hit_s5 <= hit_s4;
			for (int i = 0; i < LANES; i++) begin
				npos_s5[i] <= hit_s4 ? sat32(pos_adj[i]) : pos_s4[i];
				prev_s5[i] <= prev_s4[i];
			end
		end
		if (en[6]) begin
			hit_s6 <= hit_s5;
			for (int i = 0; i < LANES; i++) begin
				e_s6[i]    <= 33'(npos_s5[i]) - 33'(prev_s5[i]);
				npos_s6[i] <= npos_s5[i];
				prev_s6[i] <= prev_s5[i];
			end
		end
		if (en[7]) begin
			hit_s7 <= hit_s6;
			for (int i = 0; i < LANES; i++) begin
				r_s7[i]    <= 51'(e_s6[i]) * 51'(nrm_q[i]);
				npos_s7[i] <= npos_s6[i];
				prev_s7[i] <= prev_s6[i];
			end
		end
		if (en[8]) begin
			hit_s8 <= hit_s7;
			nv_s8  <= nv;
			neg_s8 <= hit_s7 && nv[36];
			for (int i = 0; i < LANES; i++) begin
				npos_s8[i] <= npos_s7[i];
				prev_s8[i] <= prev_s7[i];
			end
		end
		if (en[9]) begin
			hit_s9 <= hit_s8;
			neg_s9 <= neg_s8;
			for (int i = 0; i < LANES; i++) begin
				t_s9[i]    <= 55'(nv_s8) * 55'(nrm_q[i]);
				npos_s9[i] <= npos_s8[i];
				prev_s9[i] <= prev_s8[i];
			end
		end
		if (en[10]) begin
			hit_s10 <= hit_s9;
			for (int i = 0; i < LANES; i++) begin
				npos_s10[i]  <= npos_s9[i];
				nprev_s10[i] <= neg_s9 ? sat32(prev_adj[i]) : prev_s9[i];
			end
		end
	end

	assign out_item.valid      = v_q[NS];
	assign out_item.new_pos_x  = npos_s10[0];
	assign out_item.new_pos_y  = npos_s10[1];
	assign out_item.new_pos_z  = npos_s10[2];
	assign out_item.new_prev_x = nprev_s10[0];
	assign out_item.new_prev_y = nprev_s10[1];
	assign out_item.new_prev_z = nprev_s10[2];
	assign out_item.collided   = hit_s10;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the particle-plane collision pipeline: streams particles under
// a series of plane settings, predicts every corrected particle and checks each result.
// Depends on pcol_pkg, the channel interfaces in pcol_if.sv and plane_particle_collision_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pcol_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;

	typedef struct packed {
		logic [LANES-1:0][COORD_W-1:0] pos;
		logic [LANES-1:0][COORD_W-1:0] prev;
	} particle_t;

	typedef struct packed {
		logic [LANES-1:0][COORD_W-1:0] pos;
		logic [LANES-1:0][COORD_W-1:0] prev;
		logic                          collided;
	} correction_t;

	localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t C_ONE = 32'sh0001_0000;
	localparam norm_t  N_MAX = 18'sh1_FFFF;
	localparam norm_t  N_MIN = 18'sh2_0000;
	localparam norm_t  N_ONE = 18'sh1_0000;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int RAND_PHASES     = 12;
	localparam int HOLD_CYCLES     = 60;
	localparam int SETTLE_CYCLES   = 14;
	localparam int QUIET_LIMIT     = 1000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [31:0]      cfg_wdata;

	pcol_in_if  in_ch ();
	pcol_out_if out_ch ();

	norm_t  plane_n [LANES];
	coord_t plane_pt [LANES];
	coord_t plane_margin;

	particle_t   particles_to_send [$];
	correction_t pending_corrections [$];

	int send_idle_pct = 0, recv_idle_pct = 0;
	int offered_cnt = 0, taken_cnt = 0;
	int hold_requests = 0, hold_served = 0, hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0, checked = 0, pushed_out = 0, prev_fixed = 0, plane_settings = 1;

	plane_particle_collision_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_ch),
		.out_item  (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic coord_t clamp_coord(input longint v);
		if (v > SAT_HI)
			return C_MAX;
		if (v < SAT_LO)
			return C_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic correction_t push_out_particle(input particle_t p);
		longint nrm [LANES];
		longint pos [LANES];
		longint prev [LANES];
		longint npos [LANES];
		longint height, push, nvel;
		correction_t r;
		int i;
		height = 0;
		for (i = 0; i < LANES; i++) begin
			nrm[i]    = plane_n[i];
			pos[i]    = $signed(p.pos[i]);
			prev[i]   = $signed(p.prev[i]);
			r.pos[i]  = p.pos[i];
			r.prev[i] = p.prev[i];
			height += nrm[i] * (pos[i] - longint'(plane_pt[i]));
		end
		height = height >>> 16;
		r.collided = height < longint'(plane_margin);
		if (r.collided) begin
			push = longint'(plane_margin) - height;
			nvel = 0;
			for (i = 0; i < LANES; i++) begin
				r.pos[i] = clamp_coord(pos[i] + ((push * nrm[i]) >>> 16));
				npos[i]  = $signed(r.pos[i]);
				nvel += (npos[i] - prev[i]) * nrm[i];
			end
			nvel = nvel >>> 16;
			if (nvel < 0) begin
				for (i = 0; i < LANES; i++)
					r.prev[i] = clamp_coord(prev[i] + ((nvel * nrm[i]) >>> 16));
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input coord_t want, input coord_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_NORMAL_X: plane_n[0] = value[NORM_W-1:0];
			REG_NORMAL_Y: plane_n[1] = value[NORM_W-1:0];
			REG_NORMAL_Z: plane_n[2] = value[NORM_W-1:0];
			REG_POINT_X:  plane_pt[0] = value;
			REG_POINT_Y:  plane_pt[1] = value;
			REG_POINT_Z:  plane_pt[2] = value;
			REG_MARGIN:   plane_margin = value;
			default: ;
		endcase
	endtask

	task automatic set_plane(input norm_t nx, ny, nz, input coord_t px, py, pz, m);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_NORMAL_X, {junk[31:NORM_W], nx});
		write_reg(REG_NORMAL_Y, {junk[31:NORM_W], ny});
		write_reg(REG_NORMAL_Z, {junk[31:NORM_W], nz});
		write_reg(REG_POINT_X, px);
		write_reg(REG_POINT_Y, py);
		write_reg(REG_POINT_Z, pz);
		write_reg(REG_MARGIN, m);
		write_reg(REG_UNMAPPED, junk);
		@(negedge clk);
		cfg_we <= 1'b0;
		plane_settings++;
	endtask

	task automatic queue_particle(input coord_t px, py, pz, qx, qy, qz);
		particle_t p;
		p.pos  = {pz, py, px};
		p.prev = {qz, qy, qx};
		particles_to_send.push_back(p);
	endtask

	task automatic drain_pipeline();
		while (particles_to_send.size() != 0 || offered_cnt != taken_cnt ||
				pending_corrections.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : drive_particles
		particle_t nxt;
		if (offered_cnt == taken_cnt) begin
			if (arst_n && particles_to_send.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				nxt = particles_to_send.pop_front();
				in_ch.pos_x  <= nxt.pos[0];
				in_ch.pos_y  <= nxt.pos[1];
				in_ch.pos_z  <= nxt.pos[2];
				in_ch.prev_x <= nxt.prev[0];
				in_ch.prev_y <= nxt.prev[1];
				in_ch.prev_z <= nxt.prev[2];
				in_ch.valid  <= 1'b1;
				offered_cnt  <= offered_cnt + 1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : take_particles
		particle_t   item;
		correction_t want;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			item.pos  = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
			item.prev = {in_ch.prev_z, in_ch.prev_y, in_ch.prev_x};
			want = push_out_particle(item);
			pending_corrections.push_back(want);
			taken_cnt <= taken_cnt + 1;
			if (want.collided)
				pushed_out++;
			if (want.prev != item.prev)
				prev_fixed++;
		end
	end

	// hold off for a long stretch on request, otherwise stall at random
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served  <= hold_served + 1;
			hold_left    <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_corrections
		correction_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			checked++;
			if (pending_corrections.size() == 0) begin
				$error("corrected particle arrived with none outstanding");
				mismatches++;
			end else begin
				want = pending_corrections.pop_front();
				check_field("new_pos_x", want.pos[0], out_ch.new_pos_x);
				check_field("new_pos_y", want.pos[1], out_ch.new_pos_y);
				check_field("new_pos_z", want.pos[2], out_ch.new_pos_z);
				check_field("new_prev_x", want.prev[0], out_ch.new_prev_x);
				check_field("new_prev_y", want.prev[1], out_ch.new_prev_y);
				check_field("new_prev_z", want.prev[2], out_ch.new_prev_z);
				check_field("collided", coord_t'(want.collided), coord_t'(out_ch.collided));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, pending_corrections.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : run
		norm_t       nrm [LANES];
		coord_t      pt [LANES];
		coord_t      mgn;
		coord_t      corner [5];
		particle_t   item;
		correction_t probe;
		int          phase, k, i, kind, sel;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_NORMAL_X;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.pos_x  = '0;
		in_ch.pos_y  = '0;
		in_ch.pos_z  = '0;
		in_ch.prev_x = '0;
		in_ch.prev_y = '0;
		in_ch.prev_z = '0;
		out_ch.ready = 1'b0;
		plane_n      = '{NORMAL_X_RST, NORMAL_Y_RST, NORMAL_Z_RST};
		plane_pt     = '{POINT_RST, POINT_RST, POINT_RST};
		plane_margin = MARGIN_RST;
		corner       = '{C_MIN, C_MAX, 32'sd0, -32'sd1, C_ONE};
		send_idle_pct = 35;
		recv_idle_pct = 87;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default plane: above, on the surface, just below, in and out of it
		queue_particle(C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE);
		queue_particle(5 * C_ONE, 0, -5 * C_ONE, 0, C_ONE, 0);
		queue_particle(0, -1, 0, 0, 5 * C_ONE, 0);
		queue_particle(2 * C_ONE, -3 * C_ONE, 0, 2 * C_ONE, -6 * C_ONE, 0);
		queue_particle(0, -2 * C_ONE, 0, C_ONE, 0, -C_ONE);
		queue_particle(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
		queue_particle(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
		queue_particle(C_MAX, -1, C_MIN, C_MIN, C_MAX, C_MAX);
		queue_particle(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA);
		queue_particle(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
			32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555);
		queue_particle(0, C_MIN, 0, 0, C_MIN, 0);
		drain_pipeline();

		// push-out beyond the top of the range
		set_plane(0, N_ONE, 0, 0, C_MAX, 0, C_MAX);
		queue_particle(0, C_MIN, 0, 0, C_MIN, 0);
		queue_particle(0, C_MIN, 0, 0, C_MAX, 0);
		queue_particle(C_MIN, 0, C_MAX, -1, -1, -1);
		drain_pipeline();

		// normal of nearly twice unit length, previous position saturates
		set_plane(0, N_MAX, 0, 0, 0, 0, 0);
		queue_particle(0, -C_ONE, 0, 0, C_MAX, 0);
		queue_particle(0, C_MIN, 0, 0, 0, 0);
		queue_particle(0, C_ONE, 0, 0, 0, 0);
		drain_pipeline();

		set_plane(N_MIN, N_MAX, N_ONE, C_ONE, -C_ONE, C_MIN, 2 * C_ONE);
		queue_particle(0, 0, 0, 0, 0, 0);
		queue_particle(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
		queue_particle(-C_ONE, C_ONE, -C_ONE, -3 * C_ONE, 3 * C_ONE, -3 * C_ONE);
		drain_pipeline();

		// zero normal: always within margin, nothing moves
		set_plane(0, 0, 0, 0, 0, 0, C_ONE);
		queue_particle(3 * C_ONE, 4 * C_ONE, 5 * C_ONE, 0, 0, 0);
		queue_particle(C_MIN, C_MAX, 0, C_MAX, C_MIN, -1);
		drain_pipeline();

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase / 4)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			if ($urandom_range(9) < 4) begin
				nrm = '{18'sd0, 18'sd0, 18'sd0};
				nrm[$urandom_range(2)] = $urandom_range(1) ? N_ONE : -N_ONE;
			end else begin
				for (i = 0; i < LANES; i++) begin
					case ($urandom_range(3))
						0: nrm[i] = 18'sd0;
						1, 2: nrm[i] = norm_t'($urandom_range(131072) - 65536);
						default: nrm[i] = norm_t'($urandom);
					endcase
				end
			end
			for (i = 0; i < LANES; i++) begin
				case ($urandom_range(2))
					0: pt[i] = 32'sd0;
					1: pt[i] = int'($urandom_range(1048576)) - 524288;
					default: pt[i] = $urandom;
				endcase
			end
			case ($urandom_range(3))
				0: mgn = 32'sd0;
				1: mgn = $urandom_range(131072);
				2: mgn = -int'($urandom_range(131072));
				default: mgn = $urandom;
			endcase
			if (phase == 3) begin
				nrm = '{N_MIN, N_MIN, N_MIN};
				pt  = '{C_MAX, C_MAX, C_MAX};
				mgn = C_MIN;
			end else if (phase == 7) begin
				nrm = '{N_MAX, N_MAX, N_MAX};
				pt  = '{C_MIN, C_MIN, C_MIN};
				mgn = C_MAX;
			end
			set_plane(nrm[0], nrm[1], nrm[2], pt[0], pt[1], pt[2], mgn);

			if (phase == 8 || phase == 10)
				hold_requests++;

			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				kind = $urandom_range(99);
				for (i = 0; i < LANES; i++) begin
					if (kind < 55) begin
						item.pos[i]  = plane_pt[i] + (int'($urandom_range(524288)) - 262144);
						item.prev[i] = item.pos[i] + (int'($urandom_range(131072)) - 65536);
					end else if (kind < 80) begin
						item.pos[i]  = $urandom;
						item.prev[i] = $urandom;
					end else begin
						sel = $urandom_range(5);
						item.pos[i] = (sel == 5) ? coord_t'($urandom) : corner[sel];
						sel = $urandom_range(5);
						item.prev[i] = (sel == 5) ? coord_t'($urandom) : corner[sel];
					end
				end
				// place the previous position on the pushed-out one: no normal velocity
				if (kind >= 35 && kind < 55) begin
					item.prev = item.pos;
					probe = push_out_particle(item);
					item.prev = probe.pos;
				end
				particles_to_send.push_back(item);
			end
			drain_pipeline();
		end

		$display("%0d particles checked over %0d plane settings, random stalls on both sides",
			checked, plane_settings);
		$display("%0d pushed out of the plane, %0d with the previous position corrected",
			pushed_out, prev_fixed);
		if (mismatches == 0 && pending_corrections.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
